[rtl/stbs_pkg.sv]
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and constants for the sorted table binary search block.
// ----------------------------------------------------------------------------
package stbs_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = 8;   // index width of the table
    localparam int COUNT_W     = 9;   // entry_count register width
    localparam int RANGE_W     = 10;  // signed upper range bound
    localparam int DATA_W      = 32;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef struct packed {
        logic                     cmd;
        logic [ADDR_W-1:0]        entry_index;
        logic signed [DATA_W-1:0] data_word;
    } in_word_t;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] position;
    } out_word_t;

    // controller to datapath
    typedef struct packed {
        logic write_en;   // store the input word in the table
        logic start;      // load key and initial range
        logic read_en;    // read the table at the current midpoint
        logic step;       // narrow the range after a miss
        logic load_hit;   // load a found result into the output register
        logic load_miss;  // load a not-found result into the output register
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic range_empty;
        logic key_equal;
        logic out_free;
    } dp_status_t;

endpackage

[rtl/stbs_datapath.sv]
// ----------------------------------------------------------------------------
// stbs_datapath
// Table memory, search range registers, key compare and output register.
// ----------------------------------------------------------------------------
module stbs_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  stbs_pkg::in_word_t          s_data,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [stbs_pkg::COUNT_W-1:0] cfg_data,
    input  stbs_pkg::ctrl_cmd_t         cmd,
    output stbs_pkg::dp_status_t        status,
    input  logic                        m_ready,
    output logic                        m_valid,
    output stbs_pkg::out_word_t         m_data
);

    logic [stbs_pkg::DATA_W-1:0]         table_mem [stbs_pkg::TABLE_DEPTH];

    logic [stbs_pkg::COUNT_W-1:0]        count_reg;
    logic signed [stbs_pkg::DATA_W-1:0]  key_reg;
    logic signed [stbs_pkg::DATA_W-1:0]  rd_data_reg;
    logic [stbs_pkg::COUNT_W-1:0]        low_reg;
    logic signed [stbs_pkg::RANGE_W-1:0] high_reg;
    logic [stbs_pkg::ADDR_W-1:0]         mid_reg;
    logic                                m_valid_reg;
    stbs_pkg::out_word_t                 out_reg;

    logic [stbs_pkg::COUNT_W-1:0]        count_sat;
    logic [stbs_pkg::RANGE_W-1:0]        mid_sum;
    logic [stbs_pkg::ADDR_W-1:0]         mid;

    always_comb begin
        if (count_reg > stbs_pkg::COUNT_W'(stbs_pkg::TABLE_DEPTH)) begin
            count_sat = stbs_pkg::COUNT_W'(stbs_pkg::TABLE_DEPTH);
        end else begin
            count_sat = count_reg;
        end
    end

    // range is only probed when non-empty, so both bounds fit the table index
    assign mid_sum = {1'b0, low_reg} + {1'b0, high_reg[stbs_pkg::COUNT_W-1:0]};
    assign mid     = mid_sum[stbs_pkg::ADDR_W:1];

    assign status.range_empty = $signed({1'b0, low_reg}) > high_reg;
    assign status.key_equal   = rd_data_reg == key_reg;
    assign status.out_free    = !m_valid_reg || m_ready;

    // table memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.write_en) begin
            table_mem[s_data.entry_index] <= s_data.data_word;
        end
        if (cmd.read_en) begin
            rd_data_reg <= table_mem[mid];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            key_reg  <= s_data.data_word;
            low_reg  <= '0;
            high_reg <= $signed({1'b0, count_sat}) - stbs_pkg::RANGE_W'(1);
        end else if (cmd.step) begin
            if (rd_data_reg > key_reg) begin
                high_reg <= $signed({2'b00, mid_reg}) - stbs_pkg::RANGE_W'(1);
            end else begin
                low_reg <= {1'b0, mid_reg} + stbs_pkg::COUNT_W'(1);
            end
        end
        if (cmd.read_en) begin
            mid_reg <= mid;
        end
        if (cmd.load_hit) begin
            out_reg.found    <= 1'b1;
            out_reg.position <= mid_reg;
        end else if (cmd.load_miss) begin
            out_reg.found    <= 1'b0;
            out_reg.position <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                count_reg <= cfg_data;
            end
            if (cmd.load_hit || cmd.load_miss) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

[rtl/stbs_ctrl.sv]
// ----------------------------------------------------------------------------
// stbs_ctrl
// Sequencer for table writes and the probe / compare loop of a search.
// ----------------------------------------------------------------------------
module stbs_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_cmd,
    output logic                 s_ready,
    input  stbs_pkg::dp_status_t status,
    output stbs_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_ready = state_reg == ST_IDLE;
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_cmd == stbs_pkg::CMD_WRITE) begin
                        cmd.write_en = 1'b1;
                    end else begin
                        cmd.start  = 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                // empty range ends the search; wait here if the result slot is busy
                if (status.range_empty) begin
                    if (status.out_free) begin
                        cmd.load_miss = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end else begin
                    cmd.read_en = 1'b1;
                    state_next  = ST_CMP;
                end
            end
            ST_CMP: begin
                if (status.key_equal) begin
                    if (status.out_free) begin
                        cmd.load_hit = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    cmd.step   = 1'b1;
                    state_next = ST_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/sorted_table_binary_search.sv]
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Binary search over a table of signed 32-bit words kept in ascending order.
// ----------------------------------------------------------------------------
// A write word (cmd 0) stores data_word at entry_index and gives no result.
// A search word (cmd 1) looks for data_word in entries 0 .. entry_count-1
// (count saturated at 256) by halving the range and returns one result:
// found and the matching position, or found 0 and position 0. Each probe is
// a registered table read followed by the compare that picks the next
// midpoint. The input is held while a search runs, through at most nine
// probes for a full table of 256 entries. The result sits in an output
// register, so a finished result waiting on m_ready does not block further
// writes; a following search holds at its last step until that register is
// free. entry_count is written through the cfg port, which is always ready.
// Table entries have no reset and must be written before a search can reach
// them.
module sorted_table_binary_search (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  stbs_pkg::in_word_t           s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output stbs_pkg::out_word_t          m_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [stbs_pkg::COUNT_W-1:0] cfg_data
);

    stbs_pkg::ctrl_cmd_t  cmd;
    stbs_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    stbs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_cmd   (s_data.cmd),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    stbs_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

endmodule

[rtl/stbs_checker.sv]
// ----------------------------------------------------------------------------
// stbs_checker
// Port-level checks for the sorted table binary search block.
// ----------------------------------------------------------------------------
module stbs_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input stbs_pkg::in_word_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input stbs_pkg::out_word_t m_data
);

    // a stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.found |-> m_data.position == '0)
        else $error("position not zero on a miss");

    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a write word never produces a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.cmd == stbs_pkg::CMD_WRITE && !m_valid |=> !m_valid)
        else $error("result appeared after a write word");

    // a search keeps the input stalled while it probes
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.cmd == stbs_pkg::CMD_SEARCH |=> !s_ready)
        else $error("input ready during a search");

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
